// File: rtl/tefu_pkg.sv
// shared types, codes and sizes for the task event flag unit
// no dependencies

package tefu_pkg;

   localparam int TASKS     = 16;
   localparam int FLAG_BITS = 32;
   localparam int TASK_W    = 4;
   localparam int MASK_W    = 32;
   localparam int TIDX_W    = (TASKS > 1) ? $clog2(TASKS) : 1;

   localparam logic [2:0] OP_GET     = 3'd0;
   localparam logic [2:0] OP_SET     = 3'd1;
   localparam logic [2:0] OP_CLEAR   = 3'd2;
   localparam logic [2:0] OP_QUERY   = 3'd3;
   localparam logic [2:0] OP_TIMEOUT = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOT_MET = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_WAITING = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;

   typedef logic [FLAG_BITS-1:0] flags_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [TASK_W-1:0] task_req;
      logic [MASK_W-1:0] mask;
      logic              mode_all;
      logic              may_wait;
   } req_item_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [MASK_W-1:0] flags_seen;
      logic              woke;
   } rsp_item_type;

   function automatic logic cond_met(flags_type have, flags_type want, logic all);
      if (all) begin
         return (have & want) == want;
      end
      return (have & want) != '0;
   endfunction

endpackage

// File: rtl/tefu_in_reg.sv
// input register stage holding one accepted request word
// depends on tefu_pkg

module tefu_in_reg
   import tefu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/tefu_flag_tbl.sv
// per-task flag table with the get/set/clear/query/timeout evaluation
// depends on tefu_pkg

module tefu_flag_tbl
   import tefu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   flags_type cur_ff    [TASKS];
   flags_type wanted_ff [TASKS];
   logic      all_ff    [TASKS];
   logic      waiting_ff[TASKS];

   logic              in_range;
   logic [TIDX_W-1:0] idx;
   flags_type         m, cur, want, or_v;
   logic              w_all, w_wait;
   logic              wr_en;
   flags_type         cur_in, want_in;
   logic              all_in, wait_in;
   flags_type         seen;

   assign in_range = {1'b0, item.task_req} < (TASK_W+1)'(TASKS);
   assign idx      = TIDX_W'(item.task_req);
   assign m        = item.mask[FLAG_BITS-1:0];
   assign cur      = cur_ff[idx];
   assign want     = wanted_ff[idx];
   assign w_all    = all_ff[idx];
   assign w_wait   = waiting_ff[idx];
   assign or_v     = cur | m;

   always_comb begin
      wr_en         = 1'b0;
      cur_in        = cur;
      want_in       = want;
      all_in        = w_all;
      wait_in       = w_wait;
      seen          = '0;
      result.status = ST_INVALID;
      result.woke   = 1'b0;
      if (in_range) begin
         unique case (item.op)
            OP_GET: begin
               if (m != '0) begin
                  wr_en   = 1'b1;
                  seen    = cur;
                  want_in = '0;
                  all_in  = 1'b0;
                  wait_in = 1'b0;
                  if (cond_met(cur, m, item.mode_all)) begin
                     cur_in        = cur & ~m;
                     result.status = ST_OK;
                  end else if (!item.may_wait) begin
                     result.status = ST_NOT_MET;
                  end else begin
                     want_in       = m;
                     all_in        = item.mode_all;
                     wait_in       = 1'b1;
                     result.status = ST_WAITING;
                  end
               end
            end
            OP_SET: begin
               if (m != '0) begin
                  wr_en         = 1'b1;
                  seen          = or_v;
                  cur_in        = or_v;
                  result.status = ST_OK;
                  if (w_wait && cond_met(or_v, want, w_all)) begin
                     cur_in      = or_v & ~want;
                     want_in     = '0;
                     all_in      = 1'b0;
                     wait_in     = 1'b0;
                     result.woke = 1'b1;
                  end
               end
            end
            OP_CLEAR: begin
               if (m != '0) begin
                  wr_en         = 1'b1;
                  cur_in        = cur & ~m;
                  seen          = cur & ~m;
                  result.status = ST_OK;
               end
            end
            OP_QUERY: begin
               seen          = cur;
               result.status = ST_OK;
            end
            OP_TIMEOUT: begin
               if (w_wait) begin
                  wr_en         = 1'b1;
                  want_in       = '0;
                  all_in        = 1'b0;
                  wait_in       = 1'b0;
                  seen          = cur;
                  result.status = ST_TIMEOUT;
               end
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
      result.flags_seen = MASK_W'(seen);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASKS; i++) begin
            cur_ff[i]     <= '0;
            wanted_ff[i]  <= '0;
            all_ff[i]     <= 1'b0;
            waiting_ff[i] <= 1'b0;
         end
      end else if (fire && wr_en) begin
         cur_ff[idx]     <= cur_in;
         wanted_ff[idx]  <= want_in;
         all_ff[idx]     <= all_in;
         waiting_ff[idx] <= wait_in;
      end
   end

endmodule

// File: rtl/tefu_out_reg.sv
// result register that holds one response word until it is taken
// depends on tefu_pkg

module tefu_out_reg
   import tefu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rsp_item_type in_item,
   output logic         advance,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign advance = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (advance) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: rtl/task_event_flag_unit.sv
// task event flag unit: per-task event flags with any/all waits
// depends on tefu_pkg, tefu_in_reg, tefu_flag_tbl, tefu_out_reg
//
// usage: requests enter on the req_ stream, one word per operation (get, set,
// clear, query, timeout); every request yields exactly one word on rsp_.
// a request is registered on acceptance and evaluated against the flag table
// once the response register can take a word; the table is then written back
// and the response register is loaded in the same cycle. rsp_tvalid is high
// while the response register holds a word. throughput is one word per cycle
// while rsp_tready stays high: the table lives in flip-flops with one read and
// one write port, so a request sees the update of the one before it.
// when the receiver holds rsp_tready low the response register keeps its
// word, the input register fills, and req_tready drops; nothing is lost.
// reset clears every task's flags, wanted mask, mode and waiting state and
// empties both registers.

module task_event_flag_unit
   import tefu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // task_req[3:0], mask[35:4], mode_all[36], may_wait[37]
   input  logic [2:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // flags_seen[31:0], woke[32]
   output logic [2:0]  rsp_tuser    // status
);

   req_item_type req_item, s1_item;
   rsp_item_type tbl_result, rsp_item;
   logic         s1_valid, advance;

   assign req_item.op       = req_tuser;
   assign req_item.task_req = req_tdata[TASK_W-1:0];
   assign req_item.mask     = req_tdata[TASK_W+MASK_W-1:TASK_W];
   assign req_item.mode_all = req_tdata[TASK_W+MASK_W];
   assign req_item.may_wait = req_tdata[TASK_W+MASK_W+1];

   tefu_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .item_valid (s1_valid),
      .item       (s1_item)
   );

   tefu_flag_tbl u_flag_tbl (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_valid && advance),
      .item   (s1_item),
      .result (tbl_result)
   );

   tefu_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_item   (tbl_result),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tuser = rsp_item.status;
   assign rsp_tdata = {7'd0, rsp_item.woke, rsp_item.flags_seen};

endmodule
